### hw/rtl/mftp_pkg.sv
// ----------------------------------------------------------------------------
// mftp_pkg
// Shared types and constants for the MIDI file track chunk parser.
// ----------------------------------------------------------------------------
package mftp_pkg;

    // One byte of the track chunk body
    typedef struct packed {
        logic [7:0] data_byte;
        logic       chunk_end;
    } in_t;

    // One result item
    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] tick_time;
        logic [7:0]  status_byte;
        logic [27:0] payload_length;
        logic [7:0]  data_first;
        logic [7:0]  data_second;
        logic        last_of_event;
    } out_t;

    localparam logic [1:0] KIND_CHANNEL = 2'd0;
    localparam logic [1:0] KIND_META    = 2'd1;
    localparam logic [1:0] KIND_ESCAPE  = 2'd2;
    localparam logic [1:0] KIND_PAYLOAD = 2'd3;

    localparam logic [7:0] STATUS_SYSEX = 8'hF0;
    localparam logic [7:0] STATUS_ESC   = 8'hF7;
    localparam logic [7:0] STATUS_META  = 8'hFF;
    localparam logic [3:0] HI_PROGRAM   = 4'hC;
    localparam logic [3:0] HI_PRESSURE  = 4'hD;

    localparam logic [1:0]  QTY_LAST_BYTE = 2'd3;

    typedef enum logic [12:0] {
        PH_DELTA      = 13'b0_0000_0000_0001,
        PH_STATUS     = 13'b0_0000_0000_0010,
        PH_DATA1      = 13'b0_0000_0000_0100,
        PH_DATA2      = 13'b0_0000_0000_1000,
        PH_DATA_ONE   = 13'b0_0000_0001_0000,
        PH_META_TYPE  = 13'b0_0000_0010_0000,
        PH_LEN_META   = 13'b0_0000_0100_0000,
        PH_LEN_ESC    = 13'b0_0000_1000_0000,
        PH_LEN_SYSEX  = 13'b0_0001_0000_0000,
        PH_LEN_CONT   = 13'b0_0010_0000_0000,
        PH_PAYLOAD    = 13'b0_0100_0000_0000,
        PH_SKIP_SYSEX = 13'b0_1000_0000_0000,
        PH_SKIP_CONT  = 13'b1_0000_0000_0000
    } phase_t;

endpackage

### hw/rtl/mftp_in_stage.sv
// ----------------------------------------------------------------------------
// mftp_in_stage
// Input register: captures one byte per transfer and holds it until the
// parser consumes it.
// ----------------------------------------------------------------------------
module mftp_in_stage (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          src_valid,
    output logic          src_stall,
    input  mftp_pkg::in_t src_item,
    input  logic          advance,
    output logic          stage_valid,
    output mftp_pkg::in_t stage_item
);

    logic          valid_reg;
    logic          valid_next;
    mftp_pkg::in_t item_reg;

    assign src_stall   = valid_reg && !advance;
    assign valid_next  = src_stall ? valid_reg : src_valid;
    assign stage_valid = valid_reg;
    assign stage_item  = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (src_valid && !src_stall)
        begin
            item_reg <= src_item;
        end
    end

endmodule

### hw/rtl/mftp_parse.sv
// ----------------------------------------------------------------------------
// mftp_parse
// Track parser state and the single-pass decision for one byte: delta
// times, running status, channel/meta/escape events, SysEx skipping.
// ----------------------------------------------------------------------------
module mftp_parse (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           step,
    input  mftp_pkg::in_t  item,
    output logic           res_valid,
    output mftp_pkg::out_t res
);

    mftp_pkg::phase_t  phase_reg, phase_next, eff_phase;
    logic [7:0]        rs_reg, rs_next;
    logic [31:0]       ticks_reg, ticks_next;
    logic [27:0]       acc_reg, acc_next;
    logic [1:0]        cnt_reg, cnt_next;
    logic [27:0]       rem_reg, rem_next;
    logic [7:0]        es_reg, es_next;
    logic [7:0]        held_reg, held_next;

    logic [7:0]        b;
    logic [27:0]       qty_value;
    logic              qty_done;
    logic [27:0]       rem_dec;
    logic [3:0]        rs_hi;
    logic [3:0]        b_hi;

    assign b         = item.data_byte;
    assign qty_value = {acc_reg[20:0], b[6:0]};
    assign qty_done  = !b[7] || (cnt_reg == mftp_pkg::QTY_LAST_BYTE);
    assign rem_dec   = rem_reg - 28'd1;
    assign rs_hi     = rs_reg[7:4];
    assign b_hi      = b[7:4];

    // Resolve running status: a data byte in the status position re-enters
    // the phase that the last status selects.
    always_comb
    begin
        eff_phase = phase_reg;
        if (phase_reg == mftp_pkg::PH_STATUS && !b[7])
        begin
            priority if (rs_reg == 8'h00)
                eff_phase = mftp_pkg::PH_DELTA;
            else if (rs_reg == mftp_pkg::STATUS_SYSEX)
                eff_phase = mftp_pkg::PH_LEN_SYSEX;
            else if (rs_hi == mftp_pkg::HI_PROGRAM || rs_hi == mftp_pkg::HI_PRESSURE)
                eff_phase = mftp_pkg::PH_DATA_ONE;
            else
                eff_phase = mftp_pkg::PH_DATA1;
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        rs_next    = rs_reg;
        ticks_next = ticks_reg;
        acc_next   = acc_reg;
        cnt_next   = cnt_reg;
        rem_next   = rem_reg;
        es_next    = es_reg;
        held_next  = held_reg;

        res_valid          = 1'b0;
        res.kind           = mftp_pkg::KIND_CHANNEL;
        res.tick_time      = ticks_reg;
        res.status_byte    = es_reg;
        res.payload_length = '0;
        res.data_first     = 8'h00;
        res.data_second    = 8'h00;
        res.last_of_event  = 1'b1;

        // running status reuse of a channel status
        if (phase_reg == mftp_pkg::PH_STATUS && !b[7] && rs_reg[7]
            && rs_reg != mftp_pkg::STATUS_SYSEX)
        begin
            es_next         = rs_reg;
            res.status_byte = rs_reg;
        end

        unique case (eff_phase)
            mftp_pkg::PH_STATUS:
            begin
                priority if (b_hi != 4'hF)
                begin
                    es_next = b;
                    rs_next = b;
                    phase_next = (b_hi == mftp_pkg::HI_PROGRAM ||
                                  b_hi == mftp_pkg::HI_PRESSURE)
                                 ? mftp_pkg::PH_DATA_ONE : mftp_pkg::PH_DATA1;
                end
                else if (b == mftp_pkg::STATUS_SYSEX)
                    phase_next = mftp_pkg::PH_LEN_SYSEX;
                else if (b == mftp_pkg::STATUS_ESC)
                    phase_next = (rs_reg == mftp_pkg::STATUS_SYSEX)
                                 ? mftp_pkg::PH_LEN_CONT : mftp_pkg::PH_LEN_ESC;
                else if (b == mftp_pkg::STATUS_META)
                begin
                    rs_next    = 8'h00;
                    phase_next = mftp_pkg::PH_META_TYPE;
                end
                else
                begin
                    rs_next    = 8'h00;
                    phase_next = mftp_pkg::PH_DELTA;
                end
            end
            mftp_pkg::PH_DATA1:
            begin
                held_next  = b;
                phase_next = mftp_pkg::PH_DATA2;
            end
            mftp_pkg::PH_DATA2:
            begin
                res_valid          = 1'b1;
                res.payload_length = 28'd2;
                res.data_first     = held_reg;
                res.data_second    = b;
                phase_next         = mftp_pkg::PH_DELTA;
            end
            mftp_pkg::PH_DATA_ONE:
            begin
                res_valid          = 1'b1;
                res.payload_length = 28'd1;
                res.data_first     = b;
                phase_next         = mftp_pkg::PH_DELTA;
            end
            mftp_pkg::PH_META_TYPE:
            begin
                es_next    = b;
                phase_next = mftp_pkg::PH_LEN_META;
            end
            mftp_pkg::PH_LEN_META, mftp_pkg::PH_LEN_ESC:
            begin
                if (qty_done)
                begin
                    acc_next = '0;
                    cnt_next = 2'd0;
                    if (eff_phase == mftp_pkg::PH_LEN_ESC)
                    begin
                        es_next         = 8'h00;
                        rs_next         = 8'h00;
                        res.status_byte = 8'h00;
                        res.kind        = mftp_pkg::KIND_ESCAPE;
                    end
                    else
                    begin
                        res.kind = mftp_pkg::KIND_META;
                    end
                    res_valid          = 1'b1;
                    res.payload_length = qty_value;
                    res.last_of_event  = (qty_value == 28'd0);
                    rem_next           = qty_value;
                    phase_next = (qty_value == 28'd0) ? mftp_pkg::PH_DELTA
                                                      : mftp_pkg::PH_PAYLOAD;
                end
                else
                begin
                    acc_next = qty_value;
                    cnt_next = cnt_reg + 2'd1;
                end
            end
            mftp_pkg::PH_LEN_SYSEX, mftp_pkg::PH_LEN_CONT:
            begin
                if (qty_done)
                begin
                    acc_next = '0;
                    cnt_next = 2'd0;
                    if (qty_value == 28'd0)
                    begin
                        rs_next    = 8'h00;
                        phase_next = mftp_pkg::PH_DELTA;
                    end
                    else
                    begin
                        rem_next   = qty_value;
                        phase_next = (eff_phase == mftp_pkg::PH_LEN_SYSEX)
                                     ? mftp_pkg::PH_SKIP_SYSEX : mftp_pkg::PH_SKIP_CONT;
                    end
                end
                else
                begin
                    acc_next = qty_value;
                    cnt_next = cnt_reg + 2'd1;
                end
            end
            mftp_pkg::PH_PAYLOAD:
            begin
                rem_next           = rem_dec;
                res_valid          = 1'b1;
                res.kind           = mftp_pkg::KIND_PAYLOAD;
                res.payload_length = rem_dec;
                res.data_first     = b;
                res.last_of_event  = (rem_dec == 28'd0);
                if (rem_dec == 28'd0)
                    phase_next = mftp_pkg::PH_DELTA;
            end
            mftp_pkg::PH_SKIP_SYSEX, mftp_pkg::PH_SKIP_CONT:
            begin
                rem_next = rem_dec;
                if (rem_dec == 28'd0)
                begin
                    if (eff_phase == mftp_pkg::PH_SKIP_SYSEX)
                        rs_next = (b == mftp_pkg::STATUS_ESC) ? mftp_pkg::STATUS_SYSEX
                                                              : 8'h00;
                    else if (b == mftp_pkg::STATUS_ESC)
                        rs_next = 8'h00;
                    phase_next = mftp_pkg::PH_DELTA;
                end
            end
            default:
            begin
                // delta time byte
                phase_next = mftp_pkg::PH_DELTA;
                if (qty_done)
                begin
                    acc_next   = '0;
                    cnt_next   = 2'd0;
                    ticks_next = ticks_reg + {4'h0, qty_value};
                    phase_next = mftp_pkg::PH_STATUS;
                end
                else
                begin
                    acc_next = qty_value;
                    cnt_next = cnt_reg + 2'd1;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= mftp_pkg::PH_DELTA;
            rs_reg    <= 8'h00;
            ticks_reg <= 32'h0;
            acc_reg   <= '0;
            cnt_reg   <= 2'd0;
            rem_reg   <= '0;
            es_reg    <= 8'h00;
            held_reg  <= 8'h00;
        end
        else if (step)
        begin
            if (item.chunk_end)
            begin
                // end of track: drop any unfinished event
                phase_reg <= mftp_pkg::PH_DELTA;
                rs_reg    <= 8'h00;
                ticks_reg <= 32'h0;
                acc_reg   <= '0;
                cnt_reg   <= 2'd0;
                rem_reg   <= '0;
                es_reg    <= 8'h00;
                held_reg  <= 8'h00;
            end
            else
            begin
                phase_reg <= phase_next;
                rs_reg    <= rs_next;
                ticks_reg <= ticks_next;
                acc_reg   <= acc_next;
                cnt_reg   <= cnt_next;
                rem_reg   <= rem_next;
                es_reg    <= es_next;
                held_reg  <= held_next;
            end
        end
    end

endmodule

### hw/rtl/mftp_out_stage.sv
// ----------------------------------------------------------------------------
// mftp_out_stage
// Result register: holds one result until the downstream transfer.
// ----------------------------------------------------------------------------
module mftp_out_stage (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           stage_valid,
    input  logic           res_valid,
    input  mftp_pkg::out_t res,
    output logic           advance,
    output logic           dst_valid,
    input  logic           dst_stall,
    output mftp_pkg::out_t dst_item
);

    logic           valid_reg;
    logic           valid_next;
    logic           load;
    mftp_pkg::out_t item_reg;

    assign advance    = !valid_reg || !dst_stall;
    assign load       = advance && stage_valid && res_valid;
    assign valid_next = advance ? load : valid_reg;
    assign dst_valid  = valid_reg;
    assign dst_item   = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= res;
        end
    end

endmodule

### hw/rtl/midi_file_track_parser_core.sv
// A byte is registered in the input register on its transfer on src; its result is
// then registered in the result register, from which the dst transfer is made.
// Throughput: one byte per cycle unless dst stalls; one combinational parse pass.
// Bytes that yield no result also wait while a stalled result is held on dst.
// Reset: asynchronous, active low; parser returns to awaiting a delta time,
// ticks and running status cleared, both registers empty.
// ----------------------------------------------------------------------------
// midi_file_track_parser_core
// Standard MIDI file track chunk parser, one body byte per transfer.
// ----------------------------------------------------------------------------
module midi_file_track_parser_core (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           src_valid,
    output logic           src_stall,
    input  mftp_pkg::in_t  src_item,
    output logic           dst_valid,
    input  logic           dst_stall,
    output mftp_pkg::out_t dst_item
);

    logic           advance;
    logic           stage_valid;
    mftp_pkg::in_t  stage_item;
    logic           res_valid;
    mftp_pkg::out_t res;

    mftp_in_stage u_in (
        .clk         (clk),
        .rst_n       (rst_n),
        .src_valid   (src_valid),
        .src_stall   (src_stall),
        .src_item    (src_item),
        .advance     (advance),
        .stage_valid (stage_valid),
        .stage_item  (stage_item)
    );

    mftp_parse u_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (stage_valid && advance),
        .item      (stage_item),
        .res_valid (res_valid),
        .res       (res)
    );

    mftp_out_stage u_out (
        .clk         (clk),
        .rst_n       (rst_n),
        .stage_valid (stage_valid),
        .res_valid   (res_valid),
        .res         (res),
        .advance     (advance),
        .dst_valid   (dst_valid),
        .dst_stall   (dst_stall),
        .dst_item    (dst_item)
    );

`ifndef SYNTHESIS
    a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        src_stall |-> stage_valid)
        else $error("input stalled with an empty input register");

    a_hold_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        dst_valid && dst_stall && stage_valid |=> stage_valid && $stable(stage_item))
        else $error("parser consumed a byte while the result register was blocked");

    a_channel_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        dst_valid && !dst_item.last_of_event |-> dst_item.kind != mftp_pkg::KIND_CHANNEL)
        else $error("channel event not marked as last of event");

    a_empty_header_last: assert property (@(posedge clk) disable iff (!rst_n)
        dst_valid && dst_item.kind != mftp_pkg::KIND_CHANNEL
        && dst_item.payload_length == 28'd0 |-> dst_item.last_of_event)
        else $error("event with nothing to follow not marked as last");
`endif

endmodule
